// ===== hdl/tpcl_pkg.sv =====
// shared constants and types for the threshold promote cache list
package tpcl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths of the stream and register ports
    localparam int KEY_W    = 64;
    localparam int THR_W    = 16;
    localparam int LIMIT_W  = 5;
    localparam int HCOUNT_W = 16;
    localparam int OCC_W    = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_TDATA_W = 88;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 1'd1;

    localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 5'd4;

    // opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming transaction
        logic match;    // compare key against all cells
        logic read;     // resolve hit position, count and eviction
        logic write;    // update the list and load the result register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic pending_clear;  // item in flight is a clear
    } status_t;

endpackage

// ===== hdl/tpcl_ctrl.sv =====
// controller state machine of the threshold promote cache list
module tpcl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tpcl_pkg::status_t status,
    output tpcl_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                // a clear needs no lookup
                state_next = status.pending_clear ? ST_WRITE : ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/tpcl_datapath.sv =====
// list cells, lookup, update logic, config registers and result register
module tpcl_datapath
#(
    parameter int MAX_ENTRIES = tpcl_pkg::MAX_ENTRIES_DEF,
    parameter int COUNT_WIDTH = tpcl_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tpcl_pkg::cmd_t                   cmd,
    output tpcl_pkg::status_t                status,
    input  logic                             in_opcode,
    input  logic [tpcl_pkg::KEY_W-1:0]       in_key,
    input  logic                             cfg_we,
    input  logic [tpcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpcl_pkg::CFG_W-1:0]       cfg_data,
    output logic [tpcl_pkg::OUT_TDATA_W-1:0] result
);

    localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW    = (LEN_W > tpcl_pkg::LIMIT_W) ? LEN_W : tpcl_pkg::LIMIT_W;
    localparam int CMP_W = (COUNT_WIDTH > tpcl_pkg::THR_W) ? COUNT_WIDTH : tpcl_pkg::THR_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [LW-1:0] LIMIT_CAP = LW'(MAX_ENTRIES);

    // config registers
    logic [tpcl_pkg::THR_W-1:0]   thr_reg;
    logic [tpcl_pkg::LIMIT_W-1:0] lim_reg;

    // current item
    logic                         op_reg;
    logic [tpcl_pkg::KEY_W-1:0]   key_reg;
    logic [MAX_ENTRIES-1:0]       match_reg;

    // read stage results
    logic                         hit_reg, hit_next;
    logic                         prom_reg, prom_next;
    logic                         evict_reg, evict_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0]       cnt_reg, cnt_next;
    logic [tpcl_pkg::KEY_W-1:0]   ekey_reg, ekey_next;

    // list cells, position 0 is the front
    logic [tpcl_pkg::KEY_W-1:0]   keys_reg   [MAX_ENTRIES];
    logic [COUNT_WIDTH-1:0]       counts_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]       valid_reg;
    logic [LEN_W-1:0]             len_reg, len_next;

    logic [tpcl_pkg::OUT_TDATA_W-1:0] result_reg;

    logic [LW-1:0]                len_ext, eff_limit;
    logic [IDX_W-1:0]             rear_idx;
    logic [CMP_W-1:0]             cnt_cmp, thr_cmp;
    logic [COUNT_WIDTH-1:0]       cur_cnt;
    logic [LEN_W+tpcl_pkg::OCC_W-1:0]    occ_wide;
    logic [CMP_W+tpcl_pkg::HCOUNT_W-1:0] cnt_wide;

    assign status.pending_clear = (op_reg == tpcl_pkg::OP_CLEAR);
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tpcl_pkg::THRESHOLD_RST;
            lim_reg <= tpcl_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpcl_pkg::REG_THRESHOLD: thr_reg <= cfg_data[tpcl_pkg::THR_W-1:0];
                tpcl_pkg::REG_LIMIT:     lim_reg <= cfg_data[tpcl_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture and parallel compare
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_opcode;
            key_reg <= in_key;
        end
        if (cmd.match)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && (keys_reg[i] == key_reg);
            end
        end
    end

    // read stage: keys are unique, so the match vector has at most one bit set
    always_comb
    begin
        hit_next = |match_reg;
        pos_next = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                pos_next = pos_next | IDX_W'(i);
            end
        end
        cur_cnt  = counts_reg[pos_next];
        cnt_next = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
        if (!hit_next)
        begin
            cnt_next = COUNT_WIDTH'(1);
        end
        cnt_cmp   = CMP_W'(cnt_next);
        thr_cmp   = CMP_W'(thr_reg);
        prom_next = hit_next && (cnt_cmp > thr_cmp);

        // limit of zero acts as one, above capacity acts as capacity
        len_ext = LW'(len_reg);
        if (lim_reg == '0)
        begin
            eff_limit = LW'(1);
        end
        else if (LW'(lim_reg) > LIMIT_CAP)
        begin
            eff_limit = LIMIT_CAP;
        end
        else
        begin
            eff_limit = LW'(lim_reg);
        end
        evict_next = !hit_next && (len_ext >= eff_limit);
        rear_idx   = IDX_W'(len_reg - 1'b1);
        ekey_next  = evict_next ? keys_reg[rear_idx] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            hit_reg   <= hit_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            prom_reg  <= prom_next;
            evict_reg <= evict_next;
            ekey_reg  <= ekey_next;
        end
    end

    // new length after the write stage
    always_comb
    begin
        if (op_reg == tpcl_pkg::OP_CLEAR)
        begin
            len_next = '0;
        end
        else if (hit_reg || evict_reg)
        begin
            len_next = len_reg;
        end
        else
        begin
            len_next = len_reg + 1'b1;
        end
    end

    // write stage: every cell picks its own next value
    always_ff @(posedge clk)
    begin
        if (cmd.write && op_reg == tpcl_pkg::OP_ACCESS)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (!hit_reg || (prom_reg && IDX_W'(i) <= pos_reg))
                begin
                    // shift one place toward the rear, new front at cell 0
                    if (i == 0)
                    begin
                        keys_reg[i]   <= key_reg;
                        counts_reg[i] <= cnt_reg;
                    end
                    else
                    begin
                        keys_reg[i]   <= keys_reg[i-1];
                        counts_reg[i] <= counts_reg[i-1];
                    end
                end
                else if (!prom_reg && IDX_W'(i) == pos_reg)
                begin
                    counts_reg[i] <= cnt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            valid_reg <= '0;
        end
        else if (cmd.write)
        begin
            len_reg <= len_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i] <= (LEN_W'(i) < len_next);
            end
        end
    end

    // result fields: hit, promoted, evicted, evicted_key, hit_count, occupancy
    assign occ_wide = {{tpcl_pkg::OCC_W{1'b0}}, len_next};
    assign cnt_wide = {{tpcl_pkg::HCOUNT_W{1'b0}}, CMP_W'(cnt_reg)};

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            if (op_reg == tpcl_pkg::OP_CLEAR)
            begin
                result_reg <= '0;
            end
            else
            begin
                result_reg <= {occ_wide[tpcl_pkg::OCC_W-1:0],
                               cnt_wide[tpcl_pkg::HCOUNT_W-1:0],
                               ekey_reg, evict_reg, prom_reg, hit_reg};
            end
        end
    end

endmodule

// ===== hdl/threshold_promote_cache_list_unit.sv =====
// threshold promote cache list: top level with stream ports and config port
// sequence: after capture an access passes the match, read and write states; a clear skips the read state
// the unit takes no new item until the current one is written, and the write stage waits while a result is not taken
// the input is taken again as soon as the write stage loads the result register
// reset: asynchronous active low, empties the list and loads the register defaults
// (threshold 3, entry limit 4); no clearing pass, the unit is ready right after reset
module threshold_promote_cache_list_unit
#(
    parameter int MAX_ENTRIES = tpcl_pkg::MAX_ENTRIES_DEF,  // list capacity
    parameter int COUNT_WIDTH = tpcl_pkg::COUNT_WIDTH_DEF   // hit counter width
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tpcl_pkg::KEY_W-1:0]       s_tdata,   // [63:0] key
    input  logic                             s_tuser,   // [0] opcode
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] hit, [1] promoted, [2] evicted, [66:3] evicted_key,
    // [82:67] hit_count, [87:83] occupancy
    output logic [tpcl_pkg::OUT_TDATA_W-1:0] m_tdata,
    // config write port
    input  logic                             cfg_we,
    input  logic [tpcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpcl_pkg::CFG_W-1:0]       cfg_data
);

    // commands and status between the controller and the datapath
    tpcl_pkg::cmd_t    cmd;
    tpcl_pkg::status_t status;

    // controller sequences capture, compare, resolve (skipped for a clear) and write for each transaction,
    // and owns the result valid flag so a new item can enter while a result waits
    tpcl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath holds the list cells, compares all keys in parallel,
    // shifts entries toward the rear on insert or promotion
    tpcl_datapath
    #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_opcode (s_tuser),
        .in_key    (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (m_tdata)
    );

endmodule
